@@ rtl/core/mts_pkg.sv @@
// Shared types and constants for the min-tracking stack.
`default_nettype none
package mts_pkg;

    localparam int DATA_W    = 32;
    localparam int OCC_W     = 9;
    localparam int STATUS_W  = 2;
    localparam int RESULT_W  = 2 * DATA_W + 1 + OCC_W + STATUS_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - RESULT_W;

    typedef enum logic
    {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic push;
        logic pop;
    } lifo_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/mts_lifo.sv @@
// One stack: entry memory, registered top and registered read of the entry below the top.
`default_nettype none
module mts_lifo #(
    parameter int DEPTH = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mts_pkg::lifo_cmd_t             cmd,
    input  wire logic [mts_pkg::DATA_W-1:0]     push_data,
    output logic [$clog2(DEPTH+1)-1:0]          count,
    output logic [$clog2(DEPTH+1)-1:0]          count_next,
    output logic [mts_pkg::DATA_W-1:0]          top,
    output logic [mts_pkg::DATA_W-1:0]          top_next
);
    import mts_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] top_reg;
    logic [DATA_W-1:0] below_reg;
    logic [CNT_W-1:0]  rd_idx;

    always_comb
    begin
        priority if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = push_data;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            top_next   = below_reg;
        end
        else
        begin
            count_next = count_reg;
            top_next   = top_reg;
        end
    end

    // The entry below the new top is never the one written in the same cycle.
    assign rd_idx = count_next - CNT_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[count_reg[ADDR_W-1:0]] <= push_data;
        end
        below_reg <= mem[rd_idx[ADDR_W-1:0]];
        top_reg   <= top_next;
    end

    assign count = count_reg;
    assign top   = top_reg;

endmodule
`default_nettype wire

@@ rtl/core/min_tracking_stack.sv @@
// Top level of the min-tracking stack: input register, stack control and result register.
// Items pass the input register and then the result register. Throughput is one item
// per cycle while m_tready is high: each operation only updates the registered tops
// and issues one registered memory read of the entry below the new top in each stack.
// Reset clears both stack counts and the valid flags; the entry memories are not cleared
// and no clearing pass runs, so the block accepts items right after reset.
`default_nettype none
module min_tracking_stack #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mts_pkg::DATA_W-1:0]      s_tdata,  // value
    input  wire logic                            s_tuser,  // kind
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // top_value, min_value, is_empty, occupancy, status, zero pad
    output logic [mts_pkg::M_TDATA_W-1:0]        m_tdata
);
    import mts_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic              in_valid_reg;
    kind_t             in_kind_reg;
    logic [DATA_W-1:0] in_value_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic [DATA_W-1:0] out_min_reg;
    logic              out_empty_reg;
    logic [OCC_W-1:0]  out_occ_reg;
    status_t           out_status_reg;

    logic              advance;
    logic              is_push;
    logic              full;
    logic              empty;
    logic              take_min;
    logic              push_ok;
    logic              pop_ok;
    status_t           status_next;
    lifo_cmd_t         vcmd;
    lifo_cmd_t         mcmd;

    logic [CNT_W-1:0]  vcount;
    logic [CNT_W-1:0]  vcount_next;
    logic [DATA_W-1:0] vtop;
    logic [DATA_W-1:0] vtop_next;
    logic [CNT_W-1:0]  mcount;
    logic [CNT_W-1:0]  mcount_next;
    logic [DATA_W-1:0] mtop;
    logic [DATA_W-1:0] mtop_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign is_push  = (in_kind_reg == KIND_PUSH);
    assign full     = (vcount == CNT_W'(STACK_DEPTH));
    assign empty    = (vcount == '0);
    assign take_min = (mcount == '0) || ($signed(in_value_reg) <= $signed(mtop));
    assign push_ok  = advance && is_push && !full;
    assign pop_ok   = advance && !is_push && !empty;

    always_comb
    begin
        vcmd.push = push_ok;
        vcmd.pop  = pop_ok;
        mcmd.push = push_ok && take_min;
        mcmd.pop  = pop_ok && (mcount != '0) && (mtop == vtop);
    end

    always_comb
    begin
        priority if (is_push && full)
        begin
            status_next = STATUS_FULL;
        end
        else if (!is_push && empty)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    mts_lifo #(
        .DEPTH (STACK_DEPTH)
    ) u_value_lifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (vcmd),
        .push_data  (in_value_reg),
        .count      (vcount),
        .count_next (vcount_next),
        .top        (vtop),
        .top_next   (vtop_next)
    );

    mts_lifo #(
        .DEPTH (STACK_DEPTH)
    ) u_min_lifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (mcmd),
        .push_data  (in_value_reg),
        .count      (mcount),
        .count_next (mcount_next),
        .top        (mtop),
        .top_next   (mtop_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg  <= kind_t'(s_tuser);
            in_value_reg <= s_tdata;
        end
        if (advance)
        begin
            out_top_reg    <= (vcount_next != '0) ? vtop_next : '0;
            out_min_reg    <= ((vcount_next != '0) && (mcount_next != '0)) ? mtop_next : '0;
            out_empty_reg  <= (vcount_next == '0);
            out_occ_reg    <= OCC_W'(vcount_next);
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_status_reg, out_occ_reg, out_empty_reg,
                       out_min_reg, out_top_reg};

    a_min_not_deeper: assert property (@(posedge clk) disable iff (!rst_n)
        mcount <= vcount)
        else $error("Minimum stack holds more entries than the value stack.");

    a_push_sets_top: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (vtop == $past(in_value_reg)) && (vcount == $past(vcount) + CNT_W'(1)))
        else $error("Accepted push did not become the new top.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == STATUS_FULL) |=> (vcount == $past(vcount)))
        else $error("Push on a full stack changed the stack.");

endmodule
`default_nettype wire

@@ sim/min_tracking_stack_tb.sv @@
// Testbench for min_tracking_stack: directed and random push/pop streams checked against a predictor.
`default_nettype none
module min_tracking_stack_tb;
    import mts_pkg::*;

    localparam int          DEPTH       = 256;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [31:0] INT_MIN     = 32'h8000_0000;
    localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;

    typedef struct packed
    {
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
        logic signed [31:0] min_value;
        logic signed [31:0] top_value;
    } stack_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [31:0]   value_stack [DEPTH];
    logic [31:0]   minimum_stack [DEPTH];
    int            value_depth;
    int            minimum_depth;

    stack_result_t pending_results [$];
    int            error_count;
    int            printed_lines;
    int            cycle_count;
    int            result_count;
    bit            no_idle;

    int            push_count;
    int            pop_count;
    int            full_push_count;
    int            empty_pop_count;
    int            peak_occupancy;

    min_tracking_stack #(.STACK_DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic stack_result_t apply_stack_op(kind_t kind, logic [31:0] value);
        stack_result_t res;
        res = '0;
        res.status = STATUS_OK;
        if (kind == KIND_PUSH)
        begin
            push_count++;
            if (value_depth >= DEPTH)
            begin
                res.status = STATUS_FULL;
                full_push_count++;
            end
            else
            begin
                value_stack[value_depth] = value;
                value_depth++;
                if (minimum_depth == 0 ||
                    $signed(value) <= $signed(minimum_stack[minimum_depth-1]))
                begin
                    minimum_stack[minimum_depth] = value;
                    minimum_depth++;
                end
            end
        end
        else
        begin
            pop_count++;
            if (value_depth == 0)
            begin
                res.status = STATUS_EMPTY;
                empty_pop_count++;
            end
            else
            begin
                if (minimum_depth > 0 &&
                    minimum_stack[minimum_depth-1] == value_stack[value_depth-1])
                    minimum_depth--;
                value_depth--;
            end
        end
        if (value_depth > 0)
            res.top_value = value_stack[value_depth-1];
        if (value_depth > 0 && minimum_depth > 0)
            res.min_value = minimum_stack[minimum_depth-1];
        res.is_empty = (value_depth == 0);
        res.occupancy = value_depth[OCC_W-1:0];
        if (value_depth > peak_occupancy)
            peak_occupancy = value_depth;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 8) - 4;
        else if (r < 45)
            return INT_MIN + $urandom_range(0, 1);
        else if (r < 50)
            return INT_MAX - $urandom_range(0, 1);
        else
            return $urandom();
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (printed_lines < MAX_PRINTS)
        begin
            printed_lines++;
            $display("Mismatch on result %0d, %s: got %0d, expected %0d",
                     result_count, field, $signed(got), $signed(want));
        end
    endtask

    always @(posedge clk)
    begin
        stack_result_t got;
        stack_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RESULT_W-1:0];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.top_value !== want.top_value)
                    report_mismatch("top_value", got.top_value, want.top_value);
                if (got.min_value !== want.min_value)
                    report_mismatch("min_value", got.min_value, want.min_value);
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (m_tdata[M_TDATA_W-1:RESULT_W] !== '0)
                    report_mismatch("pad", 32'(m_tdata[M_TDATA_W-1:RESULT_W]), 32'd0);
            end
            result_count++;
        end
    end

    initial
    begin
        int run_len;
        int stall_len;
        int r;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run_len = $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run_len) @(negedge clk);
            r = $urandom_range(0, 99);
            if (no_idle || r < 40)
                stall_len = 0;
            else if (r < 90)
                stall_len = $urandom_range(1, 3);
            else
                stall_len = $urandom_range(10, 30);
            if (stall_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_len) @(negedge clk);
            end
        end
    end

    task automatic send_item(kind_t kind, logic [31:0] value);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_stack_op(kind, value));
    endtask

    task automatic test_basic_ops();
        send_item(KIND_POP, $urandom());
        send_item(KIND_PUSH, 32'd0);
        send_item(KIND_PUSH, INT_MAX);
        send_item(KIND_PUSH, INT_MIN);
        send_item(KIND_PUSH, INT_MIN);
        send_item(KIND_PUSH, 32'hFFFF_FFFF);
        send_item(KIND_PUSH, 32'd5);
        send_item(KIND_PUSH, INT_MIN);
        repeat (7) send_item(KIND_POP, $urandom());
        send_item(KIND_POP, 32'hFFFF_FFFF);
        send_item(KIND_PUSH, 32'd7);
        send_item(KIND_PUSH, 32'd7);
        send_item(KIND_PUSH, 32'd3);
        send_item(KIND_POP, 32'd0);
        send_item(KIND_POP, 32'd0);
        send_item(KIND_POP, 32'd0);
        send_item(KIND_POP, 32'd0);
    endtask

    task automatic test_full_stack();
        repeat (DEPTH) send_item(KIND_PUSH, pick_value());
        send_item(KIND_PUSH, INT_MIN);
        send_item(KIND_PUSH, $urandom());
        repeat (DEPTH / 2) send_item(KIND_POP, $urandom());
    endtask

    task automatic test_random_walk(int item_total);
        int push_percent;
        int i;
        for (i = 0; i < item_total; i++)
        begin
            if (i % 50 == 0)
            begin
                case ((i / 50) % 5)
                    0: push_percent = 85;
                    1: push_percent = 50;
                    2: push_percent = 15;
                    3: push_percent = 97;
                    default: push_percent = 40;
                endcase
                no_idle = ((i / 50) % 4 == 3);
            end
            if ($urandom_range(1, 100) <= push_percent)
                send_item(KIND_PUSH, pick_value());
            else
                send_item(KIND_POP, $urandom());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        no_idle        = 1'b0;
        error_count    = 0;
        printed_lines  = 0;
        result_count   = 0;
        value_depth    = 0;
        minimum_depth  = 0;
        push_count     = 0;
        pop_count      = 0;
        full_push_count = 0;
        empty_pop_count = 0;
        peak_occupancy = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_full_stack();
        test_random_walk(140);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d results: %0d pushes, %0d pops, peak occupancy %0d.",
                 result_count, push_count, pop_count, peak_occupancy);
        $display("Pushes while full: %0d, pops while empty: %0d, mismatches: %0d.",
                 full_push_count, empty_pop_count, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

@@ min_tracking_stack.f @@
rtl/core/mts_pkg.sv
rtl/core/mts_lifo.sv
rtl/core/min_tracking_stack.sv
sim/min_tracking_stack_tb.sv
